/* rtl/core/sdrc_pkg.sv */
// Shared types and codes for the shared DMA reset coordinator.
package sdrc_pkg;

    localparam int KIND_W   = 3;
    localparam int INDEX_W  = 3;
    localparam int STATUS_W = 3;
    localparam int MASK_W   = 8;
    localparam int COUNT_W  = 4;
    // Wide enough to compare any MAC index or sweep pointer against a depth of up to 63.
    localparam int IDX_EXT_W = 6;

    localparam logic [KIND_W-1:0] KIND_ADD        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN_DONE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ERR_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLOSED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DMA_ERROR  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd6;

    localparam logic [STATUS_W-1:0] MAC_UNLOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] MAC_LOADED    = 3'd1;
    localparam logic [STATUS_W-1:0] MAC_OPENED    = 3'd2;
    localparam logic [STATUS_W-1:0] MAC_ERRORED   = 3'd3;
    localparam logic [STATUS_W-1:0] MAC_SHUT      = 3'd4;
    localparam logic [STATUS_W-1:0] MAC_RESETTING = 3'd5;

    // Below this many present MACs the DMA may always be reset.
    localparam logic [COUNT_W-1:0] QUERY_MIN_MACS = 4'd2;

    typedef struct packed {
        logic                present;
        logic [STATUS_W-1:0] status;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                reset_dma;
        logic [MASK_W-1:0]   other_reset_mask;
        logic [STATUS_W-1:0] mac_state;
        logic [COUNT_W-1:0]  present_count;
        logic                no_effect;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } seq_state_t;

endpackage

/* rtl/core/sdrc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sdrc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sdrc_out_reg.sv */
// Output register that holds one result item until the consumer takes it.
module sdrc_out_reg
    import sdrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    output logic    load_ok,
    input  result_t res_in,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign load_ok = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

/* rtl/core/shared_dma_reset_coordinator.sv */
// Top level of the shared DMA reset coordinator: sequencer around the MAC state memory.
//
// Each MAC has a present bit and a lifecycle state held in one small RAM with a
// registered read; the present count lives in a register. An add, remove or
// lifecycle event is accepted and read, then updated and written back, and then
// handed over to the output register once that has room. A reset query that has to
// inspect the other MACs, from a loaded, error or closed MAC with at least two
// present, sweeps every entry of the memory one per cycle through its single read
// port. One item is in work at a time; a finished result waits in the output
// register while the next item is accepted. After reset every entry reads as
// absent and unloaded at once, with no clearing pass.
module shared_dma_reset_coordinator
    import sdrc_pkg::*;
#(
    parameter int MAX_MACS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [INDEX_W-1:0]  mac_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                reset_dma,
    output logic [MASK_W-1:0]   other_reset_mask,
    output logic [STATUS_W-1:0] mac_state,
    output logic [COUNT_W-1:0]  present_count,
    output logic                no_effect
);

    localparam int AW = $clog2(MAX_MACS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_MACS - 1);

    seq_state_t           state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic                 in_range_reg, in_range_next;
    logic                 sweep_reset_reg, sweep_reset_next;
    logic                 all_loaded_reg, all_loaded_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic                 reset_dma_reg, reset_dma_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic [STATUS_W-1:0]  mac_state_reg, mac_state_next;
    logic                 no_effect_reg, no_effect_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [MAX_MACS-1:0]  valid_reg, valid_next;
    logic                 rd_valid_reg, rd_valid_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    entry_t               cur_e;
    entry_t               new_e;
    logic                 self_write;
    logic [IDX_EXT_W-1:0] ptr_ext;

    logic                 out_load;
    logic                 out_load_ok;
    result_t              res_in;
    result_t              res_out;

    // Entries never written since reset read as absent and unloaded.
    assign cur_e   = rd_valid_reg ? entry_t'(ram_rdata) : '0;
    assign ptr_ext = IDX_EXT_W'(ptr_reg);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        in_range_next    = in_range_reg;
        sweep_reset_next = sweep_reset_reg;
        all_loaded_next  = all_loaded_reg;
        ptr_next         = ptr_reg;
        reset_dma_next   = reset_dma_reg;
        mask_next        = mask_reg;
        mac_state_next   = mac_state_reg;
        no_effect_next   = no_effect_reg;
        count_next       = count_reg;
        new_e            = cur_e;
        self_write       = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = ptr_reg;
        ram_wdata        = cur_e;
        ram_re           = 1'b0;
        ram_raddr        = AW'(mac_index);
        out_load         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = kind;
                    idx_next      = mac_index;
                    in_range_next = IDX_EXT_W'(mac_index) < IDX_EXT_W'(MAX_MACS);
                    ram_re        = 1'b1;
                    state_next    = S_LOOK;
                end
            end

            S_LOOK:
            begin
                reset_dma_next = 1'b0;
                mask_next      = '0;
                no_effect_next = 1'b0;
                state_next     = S_DONE;
                if (!in_range_reg)
                begin
                    no_effect_next = 1'b1;
                    mac_state_next = MAC_UNLOADED;
                end
                else
                begin
                    unique case (kind_reg) inside
                        KIND_ADD:
                        begin
                            if (cur_e.present)
                            begin
                                no_effect_next = 1'b1;
                            end
                            else
                            begin
                                new_e      = '{present: 1'b1, status: MAC_LOADED};
                                self_write = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (!cur_e.present)
                            begin
                                no_effect_next = 1'b1;
                            end
                            else
                            begin
                                new_e      = '{present: 1'b0, status: MAC_UNLOADED};
                                self_write = 1'b1;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        KIND_OPEN_DONE, KIND_ERR_DONE:
                        begin
                            new_e.status = MAC_OPENED;
                            self_write   = 1'b1;
                        end
                        KIND_CLOSED:
                        begin
                            new_e.status = MAC_SHUT;
                            self_write   = 1'b1;
                        end
                        KIND_DMA_ERROR:
                        begin
                            if (cur_e.status == MAC_RESETTING)
                            begin
                                no_effect_next = 1'b1;
                            end
                            else
                            begin
                                new_e.status = MAC_ERRORED;
                                self_write   = 1'b1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (count_reg < QUERY_MIN_MACS)
                            begin
                                reset_dma_next = 1'b1;
                            end
                            else if (cur_e.status == MAC_LOADED ||
                                     cur_e.status == MAC_ERRORED ||
                                     cur_e.status == MAC_SHUT)
                            begin
                                // A loaded MAC only checks; error or closed updates the others.
                                sweep_reset_next = (cur_e.status != MAC_LOADED);
                                reset_dma_next   = (cur_e.status != MAC_LOADED);
                                all_loaded_next  = 1'b1;
                                ptr_next         = '0;
                                ram_re           = 1'b1;
                                ram_raddr        = '0;
                                state_next       = S_SWEEP;
                            end
                        end
                        default:
                        begin
                            no_effect_next = 1'b1;
                        end
                    endcase
                    mac_state_next = new_e.status;
                    ram_we         = self_write;
                    ram_waddr      = AW'(idx_reg);
                    ram_wdata      = new_e;
                end
            end

            S_SWEEP:
            begin
                ram_waddr = ptr_reg;
                if (sweep_reset_reg)
                begin
                    if (cur_e.present && ptr_ext != IDX_EXT_W'(idx_reg))
                    begin
                        case (cur_e.status) inside
                            MAC_OPENED:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = '{present: 1'b1, status: MAC_RESETTING};
                                if (ptr_ext < IDX_EXT_W'(MASK_W))
                                begin
                                    mask_next = mask_reg | (MASK_W'(1) << ptr_ext[2:0]);
                                end
                            end
                            MAC_ERRORED, MAC_SHUT:
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = '{present: 1'b1, status: MAC_LOADED};
                            end
                            default:
                            begin
                                ram_we = 1'b0;
                            end
                        endcase
                    end
                end
                else if (cur_e.present && cur_e.status != MAC_LOADED)
                begin
                    all_loaded_next = 1'b0;
                end

                if (ptr_reg == LAST_ADDR)
                begin
                    if (!sweep_reset_reg)
                    begin
                        reset_dma_next = all_loaded_next;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    // The next entry is read while the current one is written back.
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_load_ok)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
        if (ram_re)
        begin
            rd_valid_next = valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        in_range_reg    <= in_range_next;
        sweep_reset_reg <= sweep_reset_next;
        all_loaded_reg  <= all_loaded_next;
        ptr_reg         <= ptr_next;
        reset_dma_reg   <= reset_dma_next;
        mask_reg        <= mask_next;
        mac_state_reg   <= mac_state_next;
        no_effect_reg   <= no_effect_next;
    end

    sdrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_MACS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_in = '{
        reset_dma:        reset_dma_reg,
        other_reset_mask: mask_reg,
        mac_state:        mac_state_reg,
        present_count:    count_reg,
        no_effect:        no_effect_reg
    };

    sdrc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_ok   (out_load_ok),
        .res_in    (res_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_out)
    );

    assign reset_dma        = res_out.reset_dma;
    assign other_reset_mask = res_out.other_reset_mask;
    assign mac_state        = res_out.mac_state;
    assign present_count    = res_out.present_count;
    assign no_effect        = res_out.no_effect;

endmodule

/* rtl/core/sdrc_checker.sv */
// Port-level assertions for the shared DMA reset coordinator, bound to the top level.
module sdrc_checker
    import sdrc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [KIND_W-1:0]   kind,
    input logic [INDEX_W-1:0]  mac_index,
    input logic                out_valid,
    input logic                out_ready,
    input logic                reset_dma,
    input logic [MASK_W-1:0]   other_reset_mask,
    input logic [STATUS_W-1:0] mac_state,
    input logic [COUNT_W-1:0]  present_count,
    input logic                no_effect
);

    // Only eight MACs can be addressed, so the count never passes eight.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> present_count <= 4'd8)
        else $error("present count above the number of addressable MACs");

    // MACs are only sent to reset by a query that also resets the DMA.
    a_mask_needs_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && other_reset_mask != '0 |-> reset_dma && !no_effect)
        else $error("reset mask reported without a DMA reset");

    // A query that resets the DMA always has an effect.
    a_reset_has_effect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_dma |-> !no_effect)
        else $error("DMA reset reported on an item with no effect");

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reset_dma)
            && $stable(other_reset_mask) && $stable(mac_state)
            && $stable(present_count) && $stable(no_effect))
        else $error("result item changed while stalled");

endmodule

bind shared_dma_reset_coordinator sdrc_checker u_sdrc_checker (.*);

/* dv/tb_shared_dma_reset_coordinator.sv */
// Testbench for the shared DMA reset coordinator: driver, checking monitor and MAC state predictor.
module tb_shared_dma_reset_coordinator
    import sdrc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAC_COUNT = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]  op;
        logic [INDEX_W-1:0] mac;
        bit                 pause;
    } mac_cmd_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [KIND_W-1:0]   kind = KIND_ADD;
    logic [INDEX_W-1:0]  mac_index = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                reset_dma;
    logic [MASK_W-1:0]   other_reset_mask;
    logic [STATUS_W-1:0] mac_state;
    logic [COUNT_W-1:0]  present_count;
    logic                no_effect;

    mac_cmd_t cmd_backlog[$];
    result_t  expected_results[$];

    // Predicted MAC table.
    logic                mac_on [MAC_COUNT];
    logic [STATUS_W-1:0] mac_st [MAC_COUNT];
    logic [COUNT_W-1:0]  mac_cnt;

    int n_accepted = 0;
    int n_results = 0;
    int n_fail = 0;
    int n_reset_yes = 0;
    int n_mask_hits = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;

    shared_dma_reset_coordinator #(
        .MAX_MACS(MAC_COUNT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .mac_index(mac_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .reset_dma(reset_dma),
        .other_reset_mask(other_reset_mask),
        .mac_state(mac_state),
        .present_count(present_count),
        .no_effect(no_effect)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one item to the predicted MAC table and returns its result.
    function automatic result_t apply_mac_item(logic [KIND_W-1:0] op, logic [INDEX_W-1:0] idx);
        result_t r;
        logic    all_loaded;
        int      j;
        r = '0;
        case (op)
            KIND_ADD:
            begin
                if (mac_on[idx])
                    r.no_effect = 1'b1;
                else
                begin
                    mac_on[idx] = 1'b1;
                    mac_st[idx] = MAC_LOADED;
                    mac_cnt = mac_cnt + 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (!mac_on[idx])
                    r.no_effect = 1'b1;
                else
                begin
                    mac_on[idx] = 1'b0;
                    mac_st[idx] = MAC_UNLOADED;
                    if (mac_cnt > 0)
                        mac_cnt = mac_cnt - 1'b1;
                end
            end
            KIND_OPEN_DONE, KIND_ERR_DONE: mac_st[idx] = MAC_OPENED;
            KIND_CLOSED: mac_st[idx] = MAC_SHUT;
            KIND_DMA_ERROR:
            begin
                if (mac_st[idx] == MAC_RESETTING)
                    r.no_effect = 1'b1;
                else
                    mac_st[idx] = MAC_ERRORED;
            end
            KIND_QUERY:
            begin
                if (mac_cnt < QUERY_MIN_MACS)
                    r.reset_dma = 1'b1;
                else if (mac_st[idx] == MAC_LOADED)
                begin
                    all_loaded = 1'b1;
                    for (j = 0; j < MAC_COUNT; j++)
                        if (mac_on[j] && mac_st[j] != MAC_LOADED)
                            all_loaded = 1'b0;
                    r.reset_dma = all_loaded;
                end
                else if (mac_st[idx] == MAC_ERRORED || mac_st[idx] == MAC_SHUT)
                begin
                    r.reset_dma = 1'b1;
                    // Only the other present MACs are touched; the asking one keeps its state.
                    for (j = 0; j < MAC_COUNT; j++)
                    begin
                        if (j != idx && mac_on[j])
                        begin
                            if (mac_st[j] == MAC_OPENED)
                            begin
                                mac_st[j] = MAC_RESETTING;
                                r.other_reset_mask[j] = 1'b1;
                            end
                            else if (mac_st[j] == MAC_ERRORED || mac_st[j] == MAC_SHUT)
                                mac_st[j] = MAC_LOADED;
                        end
                    end
                end
            end
            default: r.no_effect = 1'b1;
        endcase
        r.mac_state = mac_st[idx];
        r.present_count = mac_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic queue_item(logic [KIND_W-1:0] op, logic [INDEX_W-1:0] mac);
        mac_cmd_t c;
        c.op = op;
        c.mac = mac;
        c.pause = 1'b0;
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_pause();
        mac_cmd_t c;
        c.op = KIND_ADD;
        c.mac = '0;
        c.pause = 1'b1;
        cmd_backlog.push_back(c);
    endtask

    // Driver: presents queued items after a random gap, none in every fourth batch of 150.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        mac_cmd_t c;
        logic     nxt_valid;
        int       nxt_gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= KIND_ADD;
            mac_index <= '0;
            send_gap <= 0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_gap = send_gap;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(apply_mac_item(kind, mac_index));
                n_accepted <= n_accepted + 1;
                nxt_valid = 1'b0;
                nxt_gap = (((n_accepted / 150) % 4) == 2) ? 0 : $urandom_range(0, 3);
            end
            if (!nxt_valid)
            begin
                if (nxt_gap > 0)
                    nxt_gap--;
                else if (cmd_backlog.size() > 0)
                begin
                    // A pause entry holds the sender until every outstanding result is back.
                    if (cmd_backlog[0].pause)
                    begin
                        if (expected_results.size() == 0)
                            void'(cmd_backlog.pop_front());
                    end
                    else
                    begin
                        c = cmd_backlog.pop_front();
                        kind <= c.op;
                        mac_index <= c.mac;
                        nxt_valid = 1'b1;
                    end
                end
            end
            in_valid <= nxt_valid;
            send_gap <= nxt_gap;
        end
    end

    // One long receiver hold-off while the sender keeps offering items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_accepted >= 500)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: takes each result and checks it against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        result_t want;
        int      nxt_stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            nxt_stall = recv_stall;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    n_fail++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("reset_dma", want.reset_dma, reset_dma);
                    check_field("other_reset_mask", want.other_reset_mask, other_reset_mask);
                    check_field("mac_state", want.mac_state, mac_state);
                    check_field("present_count", want.present_count, present_count);
                    check_field("no_effect", want.no_effect, no_effect);
                    if (want.reset_dma)
                        n_reset_yes++;
                    if (want.other_reset_mask != '0)
                        n_mask_hits++;
                end
                n_results++;
                nxt_stall = (((n_results / 150) % 4) == 1) ? 0 : $urandom_range(0, 3);
            end
            else if (nxt_stall > 0)
                nxt_stall--;
            recv_stall <= nxt_stall;
            out_ready <= (nxt_stall == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("tb_shared_dma_reset_coordinator NOT OK");
            $finish;
        end
    end

    initial
    begin
        int roll;
        int n;
        logic [KIND_W-1:0] op;

        for (n = 0; n < MAC_COUNT; n++)
        begin
            mac_on[n] = 1'b0;
            mac_st[n] = MAC_UNLOADED;
        end
        mac_cnt = '0;

        // Directed walk through the lifecycle and the query rules.
        queue_item(KIND_QUERY, 3'd0);        // nothing present: always yes
        queue_item(KIND_ADD, 3'd0);
        queue_item(KIND_QUERY, 3'd0);        // one present: still yes
        queue_item(KIND_ADD, 3'd0);          // duplicate add
        queue_item(KIND_ADD, 3'd7);
        queue_item(KIND_QUERY, 3'd7);        // every present MAC loaded
        queue_item(KIND_OPEN_DONE, 3'd7);
        queue_item(KIND_QUERY, 3'd0);        // loaded asker, but another is opened
        queue_item(KIND_QUERY, 3'd7);        // opened asker
        queue_item(KIND_ADD, 3'd3);
        queue_item(KIND_CLOSED, 3'd3);
        queue_item(KIND_DMA_ERROR, 3'd0);
        queue_item(KIND_QUERY, 3'd0);        // error asker resets MAC 7, reloads MAC 3
        queue_item(KIND_DMA_ERROR, 3'd7);    // ignored while in reset
        queue_item(KIND_QUERY, 3'd7);        // reset asker
        queue_item(KIND_ERR_DONE, 3'd7);
        queue_item(KIND_REMOVE, 3'd5);       // remove of an absent MAC
        queue_item(KIND_CLOSED, 3'd5);       // event on an absent MAC still moves it
        queue_item(KIND_QUERY, 3'd5);        // absent asker judged by its own state
        queue_item(KIND_UNUSED, 3'd5);
        queue_item(KIND_ADD, 3'd5);
        queue_item(KIND_REMOVE, 3'd0);
        queue_item(KIND_REMOVE, 3'd7);
        queue_pause();

        // Random part, weighted toward events and queries so the table stays populated.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
                op = KIND_ADD;
            else if (roll < 22)
                op = KIND_REMOVE;
            else if (roll < 36)
                op = KIND_OPEN_DONE;
            else if (roll < 43)
                op = KIND_ERR_DONE;
            else if (roll < 53)
                op = KIND_CLOSED;
            else if (roll < 65)
                op = KIND_DMA_ERROR;
            else if (roll < 97)
                op = KIND_QUERY;
            else
                op = KIND_UNUSED;
            queue_item(op, INDEX_W'($urandom_range(0, MAC_COUNT - 1)));
            if (n == 900)
                queue_pause();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d items sent, %0d results checked", n_accepted, n_results);
        $display("%0d queries allowed a DMA reset, %0d of them put other MACs into reset",
                 n_reset_yes, n_mask_hits);
        if (n_fail == 0 && expected_results.size() == 0)
            $display("tb_shared_dma_reset_coordinator OK");
        else
            $display("tb_shared_dma_reset_coordinator NOT OK");
        $finish;
    end

endmodule
